### design/vctq_pkg.sv
// shared types, constants and codes for the virtual clock timer queue
package vctq_pkg;

  // table geometry
  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int unsigned OWNER_BITS  = 8;
  localparam int unsigned MAX_FIRE    = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_FIRE + 1);

  // field widths
  localparam int unsigned CLOCK_W = 48;
  localparam int unsigned ID_W    = 16;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
  localparam logic [ID_W-1:0]    ID_MAX    = {ID_W{1'b1}};
  localparam logic [ID_W-1:0]    ID_FIRST  = ID_W'(1);

  // command codes
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_CANCELED = 3'd1;
  localparam logic [2:0] ST_FIRED    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BEYOND   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // input item
  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        delay_ms;
    logic [7:0]         owner;
    logic               alarm_kind;
    logic [ID_W-1:0]    cancel_id;
    logic [CLOCK_W-1:0] time_limit;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    timer_id;
    logic [7:0]         fired_owner;
    logic               fired_alarm;
    logic [CLOCK_W-1:0] clock_now;
    logic               last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       scan_clr;
    logic       scan_step;
    logic       scan_all;
    logic       cancel_step;
    logic       add_do;
    logic       first_take;
    logic       next_take;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_last;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;
    logic full;
    logic found;
    logic beyond;
    logic cnt_max;
    logic out_free;
  } sts_t;

endpackage

### design/vctq_ctrl.sv
// controller state machine for the virtual clock timer queue
module vctq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_cmd,
  output logic          in_ready,
  input  vctq_pkg::sts_t sts,
  output vctq_pkg::ctl_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_CANCEL = 3'd2;
  localparam logic [2:0] S_SCAN1  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_SCAN2  = 3'd5;
  localparam logic [2:0] S_FIRE   = 3'd6;
  localparam logic [2:0] S_ONE    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch    = 1'b1;
          ctl.scan_clr = 1'b1;
          case (in_cmd)
            vctq_pkg::CMD_ADD:     state_nxt = S_ADD;
            vctq_pkg::CMD_CANCEL:  state_nxt = S_CANCEL;
            vctq_pkg::CMD_ADVANCE: state_nxt = S_SCAN1;
            default: begin
              st_nxt    = vctq_pkg::ST_FULL;
              state_nxt = S_ONE;
            end
          endcase
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_last   = 1'b1;
          ctl.add_do      = !sts.full;
          ctl.emit_status = sts.full ? vctq_pkg::ST_FULL : vctq_pkg::ST_ADDED;
          state_nxt       = S_IDLE;
        end
      end
      S_CANCEL: begin
        ctl.cancel_step = 1'b1;
        if (sts.scan_end) begin
          st_nxt    = vctq_pkg::ST_CANCELED;
          state_nxt = S_ONE;
        end
      end
      S_SCAN1: begin
        ctl.scan_step = 1'b1;
        ctl.scan_all  = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.found) begin
          st_nxt    = vctq_pkg::ST_EMPTY;
          state_nxt = S_ONE;
        end else if (sts.beyond) begin
          st_nxt    = vctq_pkg::ST_BEYOND;
          state_nxt = S_ONE;
        end else begin
          ctl.first_take = 1'b1;
          ctl.scan_clr   = 1'b1;
          state_nxt      = S_SCAN2;
        end
      end
      S_SCAN2: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_FIRE;
        end
      end
      S_FIRE: begin
        // the held timer goes out once we know whether another is due
        if (sts.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = vctq_pkg::ST_FIRED;
          ctl.emit_last   = !sts.found || sts.cnt_max;
          if (sts.found && !sts.cnt_max) begin
            ctl.next_take = 1'b1;
            ctl.scan_clr  = 1'b1;
            state_nxt     = S_SCAN2;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_last   = 1'b1;
          ctl.emit_status = st_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= vctq_pkg::ST_ADDED;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

### design/vctq_datapath.sv
// timer table, virtual clock, scan unit and result register
module vctq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  vctq_pkg::in_item_t in_data,
  input  vctq_pkg::ctl_t     ctl,
  output vctq_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output vctq_pkg::out_item_t out_data
);

  localparam int unsigned N  = vctq_pkg::TIMER_SLOTS;
  localparam int unsigned SW = vctq_pkg::SLOT_W;
  localparam int unsigned CW = vctq_pkg::CLOCK_W;
  localparam int unsigned IW = vctq_pkg::ID_W;
  localparam int unsigned OW = vctq_pkg::OWNER_BITS;
  localparam int unsigned KW = vctq_pkg::CNT_W;

  // slot table
  logic [N-1:0]  valid_r, valid_nxt;
  logic [CW-1:0] dl_r    [N];
  logic [IW-1:0] id_r    [N];
  logic [OW-1:0] owner_r [N];
  logic          alarm_r [N];

  // clock, id counter and latched command fields
  logic [CW-1:0] clock_r, clock_nxt;
  logic [IW-1:0] next_id_r, next_id_nxt;
  logic [31:0]   delay_r;
  logic [OW-1:0] own_in_r;
  logic          alarm_in_r;
  logic [IW-1:0] cancel_id_r;
  logic [CW-1:0] limit_r;

  // scan state and best candidate
  logic [SW-1:0]          idx_r, idx_nxt;
  logic                   found_r, found_nxt;
  logic [CW-1:0]          best_dl_r;
  logic [IW-1:0]          best_id_r;
  logic [OW-1:0]          best_own_r;
  logic                   best_alarm_r;
  logic [SW-1:0]          best_idx_r;
  logic                   take_best;

  // held fired timer and fire count
  logic [IW-1:0]               pend_id_r;
  logic [OW-1:0]               pend_own_r;
  logic                        pend_alarm_r;
  logic [KW-1:0]               cnt_r, cnt_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  vctq_pkg::out_item_t out_r;

  logic [SW-1:0] free_idx;
  logic [CW:0]   dl_sum;
  logic [CW-1:0] dl_new;
  logic          cur_valid, in_bound, better;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  // saturating deadline
  assign dl_sum = {1'b0, clock_r} + {{(CW + 1 - 32){1'b0}}, delay_r};
  assign dl_new = dl_sum[CW] ? vctq_pkg::CLOCK_MAX : dl_sum[CW-1:0];

  // one slot compared per scan cycle
  assign cur_valid = valid_r[idx_r];
  assign in_bound  = ctl.scan_all || (dl_r[idx_r] <= clock_r);
  assign better    = !found_r || (dl_r[idx_r] < best_dl_r) ||
                     ((dl_r[idx_r] == best_dl_r) && (id_r[idx_r] < best_id_r));
  assign take_best = ctl.scan_step && cur_valid && in_bound && better;

  // control next values
  always_comb begin
    valid_nxt     = valid_r;
    clock_nxt     = clock_r;
    next_id_nxt   = next_id_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;

    if (ctl.scan_step || ctl.cancel_step) begin
      idx_nxt = idx_r + SW'(1);
    end
    if (take_best) begin
      found_nxt = 1'b1;
    end
    if (ctl.cancel_step && cur_valid && (id_r[idx_r] == cancel_id_r)) begin
      valid_nxt[idx_r] = 1'b0;
    end
    if (ctl.add_do) begin
      valid_nxt[free_idx] = 1'b1;
      next_id_nxt = (next_id_r == vctq_pkg::ID_MAX) ? vctq_pkg::ID_FIRST
                                                    : next_id_r + IW'(1);
    end
    if (ctl.first_take) begin
      if (best_dl_r > clock_r) begin
        clock_nxt = best_dl_r;
      end
      valid_nxt[best_idx_r] = 1'b0;
      cnt_nxt = KW'(1);
    end
    if (ctl.next_take) begin
      valid_nxt[best_idx_r] = 1'b0;
      cnt_nxt = cnt_r + KW'(1);
    end
    if (ctl.scan_clr) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      clock_r     <= '0;
      next_id_r   <= vctq_pkg::ID_FIRST;
      idx_r       <= '0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      clock_r     <= clock_nxt;
      next_id_r   <= next_id_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      delay_r     <= in_data.delay_ms;
      own_in_r    <= OW'(in_data.owner);
      alarm_in_r  <= in_data.alarm_kind;
      cancel_id_r <= in_data.cancel_id;
      limit_r     <= in_data.time_limit;
    end
    if (ctl.add_do) begin
      dl_r[free_idx]    <= dl_new;
      id_r[free_idx]    <= next_id_r;
      owner_r[free_idx] <= own_in_r;
      alarm_r[free_idx] <= alarm_in_r;
    end
    if (take_best) begin
      best_dl_r    <= dl_r[idx_r];
      best_id_r    <= id_r[idx_r];
      best_own_r   <= owner_r[idx_r];
      best_alarm_r <= alarm_r[idx_r];
      best_idx_r   <= idx_r;
    end
    if (ctl.first_take || ctl.next_take) begin
      pend_id_r    <= best_id_r;
      pend_own_r   <= best_own_r;
      pend_alarm_r <= best_alarm_r;
    end
    if (ctl.emit) begin
      out_r.status    <= ctl.emit_status;
      out_r.clock_now <= clock_r;
      out_r.last      <= ctl.emit_last;
      if (ctl.emit_status == vctq_pkg::ST_ADDED) begin
        out_r.timer_id    <= next_id_r;
        out_r.fired_owner <= '0;
        out_r.fired_alarm <= 1'b0;
      end else if (ctl.emit_status == vctq_pkg::ST_FIRED) begin
        out_r.timer_id    <= pend_id_r;
        out_r.fired_owner <= 8'(pend_own_r);
        out_r.fired_alarm <= pend_alarm_r;
      end else begin
        out_r.timer_id    <= '0;
        out_r.fired_owner <= '0;
        out_r.fired_alarm <= 1'b0;
      end
    end
  end

  // status to controller
  assign sts.scan_end = (idx_r == SW'(N - 1));
  assign sts.full     = &valid_r;
  assign sts.found    = found_r;
  assign sts.beyond   = (best_dl_r > limit_r);
  assign sts.cnt_max  = (cnt_r == KW'(vctq_pkg::MAX_FIRE));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/virtual_clock_timer_queue_unit.sv
// top level of the virtual clock timer queue
//
// Holds up to TIMER_SLOTS pending timers and a 48-bit virtual millisecond
// clock. Commands arrive as items on the in_ channel (valid/ready): add,
// cancel by id, advance and fire, read clock. Results leave on the out_
// channel (valid/ready); every command gives one result except an advance
// that fires, which gives one result per fired timer, with last on the
// final one.
// One command is worked at a time; in_ready is high only while idle.
// Cancel makes one pass over the table. An advance makes one pass to find
// the earliest deadline, then one full pass of the single slot comparator
// over the table per fired timer.
// The result register lets the block take the next command while a result
// waits; when the receiver stalls, the block waits in place before loading
// the next result. Reset (rst_n low, synchronous) empties the table, sets
// the clock to zero and the next id to one; no clearing pass is needed.
module virtual_clock_timer_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vctq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vctq_pkg::out_item_t out_data
);

  vctq_pkg::ctl_t ctl;
  vctq_pkg::sts_t sts;

  // command sequencing
  vctq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // table, clock and result register
  vctq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/testbench.sv
// self-checking bench for the virtual clock timer queue: paced stimulus, predictor, result checks
module testbench;

  localparam int unsigned SLOTS       = vctq_pkg::TIMER_SLOTS;
  localparam int unsigned CW          = vctq_pkg::CLOCK_W;
  localparam int unsigned IW          = vctq_pkg::ID_W;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned TAIL_CYCLES = 2 * (SLOTS + 2) + 8;
  localparam logic [31:0] DELAY_TOP   = 32'hFFFF_FFFF;

  // one copy of the timer table as the block should hold it
  typedef struct packed {
    logic [SLOTS-1:0]               used;
    logic [SLOTS-1:0][CW-1:0]       dl;
    logic [SLOTS-1:0][IW-1:0]       id;
    logic [SLOTS-1:0][7:0]          owner;
    logic [SLOTS-1:0]               alarm;
    logic [CW-1:0]                  now;
    logic [IW-1:0]                  nid;
  } timer_table_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  vctq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  vctq_pkg::out_item_t out_data;

  vctq_pkg::in_item_t  cmd_queue[$];
  vctq_pkg::out_item_t due_results[$];
  vctq_pkg::out_item_t want_result;
  timer_table_t        track_table;
  timer_table_t        plan_table;
  int                  send_idle_pct = 17;
  int                  recv_idle_pct = 71;
  int                  fail_count = 0;
  int                  cmds_taken = 0;
  int                  results_seen = 0;
  int unsigned         cycle_count = 0;

  virtual_clock_timer_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // empty table, clock at zero, first id one
  function automatic timer_table_t fresh_table();
    timer_table_t t;
    t     = '0;
    t.nid = vctq_pkg::ID_FIRST;
    return t;
  endfunction

  // earliest live slot with deadline within bound, ties to the lower id, then lower slot
  function automatic int earliest_due(input timer_table_t t, input logic [CW-1:0] bound);
    int best, i;
    best = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (t.used[i] && t.dl[i] <= bound) begin
        if (best < 0 || t.dl[i] < t.dl[best] ||
            (t.dl[i] == t.dl[best] && t.id[i] < t.id[best]))
          best = i;
      end
    end
    return best;
  endfunction

  // apply one command to a table; with record set the results are queued as due
  task automatic timer_queue_step(inout timer_table_t t, input vctq_pkg::in_item_t it,
                                  input bit record);
    int slot, hit, n, i;
    logic [CW:0]         sum;
    logic [CW-1:0]       deadline;
    vctq_pkg::out_item_t res;
    res      = '0;
    res.last = 1'b1;
    n        = 0;
    case (it.cmd)
      vctq_pkg::CMD_ADD: begin
        slot = -1;
        for (i = SLOTS - 1; i >= 0; i--)
          if (!t.used[i]) slot = i;
        if (slot < 0) begin
          res.status = vctq_pkg::ST_FULL;
        end else begin
          // deadline saturates at the top of the clock
          sum      = {1'b0, t.now} + {{(CW + 1 - 32){1'b0}}, it.delay_ms};
          deadline = (sum > {1'b0, vctq_pkg::CLOCK_MAX}) ? vctq_pkg::CLOCK_MAX
                                                          : sum[CW-1:0];
          t.used[slot]  = 1'b1;
          t.dl[slot]    = deadline;
          t.id[slot]    = t.nid;
          t.owner[slot] = it.owner & 8'((1 << vctq_pkg::OWNER_BITS) - 1);
          t.alarm[slot] = it.alarm_kind;
          res.status    = vctq_pkg::ST_ADDED;
          res.timer_id  = t.nid;
          t.nid = (t.nid == vctq_pkg::ID_MAX) ? vctq_pkg::ID_FIRST : t.nid + 1'b1;
        end
      end
      vctq_pkg::CMD_CANCEL: begin
        for (i = 0; i < SLOTS; i++)
          if (t.used[i] && t.id[i] == it.cancel_id) t.used[i] = 1'b0;
        res.status = vctq_pkg::ST_CANCELED;
      end
      vctq_pkg::CMD_ADVANCE: begin
        hit = earliest_due(t, vctq_pkg::CLOCK_MAX);
        if (hit < 0) begin
          res.status = vctq_pkg::ST_EMPTY;
        end else if (t.dl[hit] > it.time_limit) begin
          res.status = vctq_pkg::ST_BEYOND;
        end else begin
          // clock never moves backwards
          if (t.dl[hit] > t.now) t.now = t.dl[hit];
          hit = earliest_due(t, t.now);
          while (hit >= 0 && n < vctq_pkg::MAX_FIRE) begin
            t.used[hit]     = 1'b0;
            res.status      = vctq_pkg::ST_FIRED;
            res.timer_id    = t.id[hit];
            res.fired_owner = t.owner[hit];
            res.fired_alarm = t.alarm[hit];
            res.clock_now   = t.now;
            n++;
            hit      = earliest_due(t, t.now);
            res.last = (n == vctq_pkg::MAX_FIRE) || (hit < 0);
            if (record) due_results.insert(due_results.size(), res);
          end
        end
      end
      default: begin
        // clock read shares its status code with table full
        res.status = vctq_pkg::ST_FULL;
      end
    endcase
    if (n == 0) begin
      res.clock_now = t.now;
      if (record) due_results.insert(due_results.size(), res);
    end
  endtask

  // build a command item
  function automatic vctq_pkg::in_item_t command_item(input logic [1:0] cmd,
                                                      input logic [31:0] delay,
                                                      input logic [7:0] owner,
                                                      input logic alarm,
                                                      input logic [IW-1:0] cid,
                                                      input logic [CW-1:0] limit);
    vctq_pkg::in_item_t it;
    it.cmd        = cmd;
    it.delay_ms   = delay;
    it.owner      = owner;
    it.alarm_kind = alarm;
    it.cancel_id  = cid;
    it.time_limit = limit;
    return it;
  endfunction

  // random command shaped by the planned table: live ids, limits at the earliest deadline
  function automatic vctq_pkg::in_item_t pick_command(input timer_table_t t);
    vctq_pkg::in_item_t it;
    int roll, pick, slot, head, i;
    it.cmd        = 2'($urandom);
    it.delay_ms   = $urandom;
    it.owner      = 8'($urandom);
    it.alarm_kind = 1'($urandom);
    it.cancel_id  = IW'($urandom);
    it.time_limit = CW'({$urandom, $urandom});
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    if (roll < 45) begin
      it.cmd = vctq_pkg::CMD_ADD;
      case (pick)
        0, 1, 2, 3: it.delay_ms = $urandom_range(20);
        4, 5:       it.delay_ms = $urandom_range(2000);
        6:          it.delay_ms = DELAY_TOP;
        7:          it.delay_ms = '0;
        default:    ;
      endcase
    end else if (roll < 65) begin
      it.cmd = vctq_pkg::CMD_CANCEL;
      slot   = -1;
      if (pick < 7) begin
        head = $urandom_range(SLOTS - 1);
        for (i = 0; i < SLOTS; i++)
          if (slot < 0 && t.used[(head + i) % SLOTS]) slot = (head + i) % SLOTS;
      end
      if (slot >= 0) it.cancel_id = t.id[slot];
      else if (pick == 7) it.cancel_id = t.nid - 1'b1;
      else if (pick == 8) it.cancel_id = '0;
    end else if (roll < 90) begin
      it.cmd = vctq_pkg::CMD_ADVANCE;
      head   = earliest_due(t, vctq_pkg::CLOCK_MAX);
      case (pick)
        0, 1, 2, 3: it.time_limit = vctq_pkg::CLOCK_MAX;
        4, 5:       if (head >= 0) it.time_limit = t.dl[head];
        6, 7:       if (head >= 0 && t.dl[head] != '0) it.time_limit = t.dl[head] - 1'b1;
        8:          it.time_limit = t.now + CW'($urandom_range(64));
        default:    ;
      endcase
    end else begin
      it.cmd = vctq_pkg::CMD_READ;
    end
    return it;
  endfunction

  // queue a command, keeping the planned table in step, with a short backlog
  task automatic send_cmd(input vctq_pkg::in_item_t it);
    timer_queue_step(plan_table, it, 1'b0);
    cmd_queue.insert(cmd_queue.size(), it);
    while (cmd_queue.size() > 32) @(negedge clk);
  endtask

  // wait until every queued command is taken and every due result has come
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
  endtask

  // one field check
  task automatic check_field(input string field, input logic [CW-1:0] exp_v,
                             input logic [CW-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, actual %0h", field, exp_v, got_v);
      fail_count++;
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver pacing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on every taken command, check every taken result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        timer_queue_step(track_table, in_data, 1'b1);
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result with none due: status %0d, id %0d", out_data.status, out_data.timer_id);
          fail_count++;
        end else begin
          want_result = due_results.pop_front();
          check_field("status", CW'(want_result.status), CW'(out_data.status));
          check_field("timer_id", CW'(want_result.timer_id), CW'(out_data.timer_id));
          check_field("fired_owner", CW'(want_result.fired_owner), CW'(out_data.fired_owner));
          check_field("fired_alarm", CW'(want_result.fired_alarm), CW'(out_data.fired_alarm));
          check_field("clock_now", want_result.clock_now, out_data.clock_now);
          check_field("last", CW'(want_result.last), CW'(out_data.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    int i;
    track_table = fresh_table();
    plan_table  = fresh_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes of delay and owner, limits at the deadline
    send_cmd(command_item(vctq_pkg::CMD_ADVANCE, 0, 0, 0, 0, vctq_pkg::CLOCK_MAX));
    send_cmd(command_item(vctq_pkg::CMD_ADD, 32'd0, 8'h00, 1'b0, 0, 0));
    send_cmd(command_item(vctq_pkg::CMD_ADD, DELAY_TOP, 8'hFF, 1'b1, 0, 0));
    send_cmd(command_item(vctq_pkg::CMD_ADD, 32'd10, 8'hA5, 1'b1, 0, 0));
    send_cmd(command_item(vctq_pkg::CMD_ADD, 32'd10, 8'h5A, 1'b0, 0, 0));
    // deadline equal to the clock fires without moving it
    send_cmd(command_item(vctq_pkg::CMD_ADVANCE, 0, 0, 0, 0, '0));
    // limit one below the earliest deadline
    send_cmd(command_item(vctq_pkg::CMD_ADVANCE, 0, 0, 0, 0, CW'(9)));
    // tie on deadline fires in id order
    send_cmd(command_item(vctq_pkg::CMD_ADVANCE, 0, 0, 0, 0, vctq_pkg::CLOCK_MAX));
    send_cmd(command_item(vctq_pkg::CMD_CANCEL, 0, 0, 0, IW'(2), 0));
    send_cmd(command_item(vctq_pkg::CMD_READ, 0, 0, 0, 0, 0));
    // fill the table, overflow it, then fire all of it in one run
    for (i = 0; i < SLOTS; i++)
      send_cmd(command_item(vctq_pkg::CMD_ADD, 32'd7, 8'(i * 17), 1'(i), 0, 0));
    send_cmd(command_item(vctq_pkg::CMD_ADD, 32'd3, 8'h3C, 1'b1, 0, 0));
    send_cmd(command_item(vctq_pkg::CMD_ADVANCE, 0, 0, 0, 0, vctq_pkg::CLOCK_MAX));

    repeat (130) send_cmd(pick_command(plan_table));
    drain();
    send_idle_pct = 71;
    recv_idle_pct = 17;
    repeat (130) send_cmd(pick_command(plan_table));
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (120) send_cmd(pick_command(plan_table));

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("checked %0d commands and %0d results under three pacing mixes,", cmds_taken,
             results_seen);
    $display("with empty, full and overflowing tables, limit edges and deadline ties");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
